// ===== hdl/gcf_pkg.sv =====
// Shared types, codes and helpers for the graphics command queue.
package gcf_pkg;

    localparam int CODE_W  = 8;
    localparam int PARAM_W = 32;

    localparam int THRESHOLD_RESET = 127;

    localparam logic [CODE_W-1:0] CMD_STACK_PUSH = 8'h11;
    localparam logic [CODE_W-1:0] CMD_STACK_POP  = 8'h12;

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    typedef struct packed {
        logic pop_valid;
        logic overflow;
    } stage_flags_t;

    function automatic logic is_stack_cmd(input logic [CODE_W-1:0] code);
        return (code == CMD_STACK_PUSH) || (code == CMD_STACK_POP);
    endfunction

endpackage

// ===== hdl/gcf_store.sv =====
// Entry memory: one write port and one registered read port.
module gcf_store #(
    parameter int QUEUE_DEPTH = 256,
    localparam int PTR_W = $clog2(QUEUE_DEPTH)
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [PTR_W-1:0]             wr_addr,
    input  logic [gcf_pkg::CODE_W-1:0]   wr_code,
    input  logic [gcf_pkg::PARAM_W-1:0]  wr_param,
    input  logic                         rd_en,
    input  logic [PTR_W-1:0]             rd_addr,
    output logic [gcf_pkg::CODE_W-1:0]   rd_code,
    output logic [gcf_pkg::PARAM_W-1:0]  rd_param
);
    import gcf_pkg::*;

    logic [CODE_W+PARAM_W-1:0] mem [QUEUE_DEPTH];
    logic [CODE_W+PARAM_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_param, wr_code};
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_code  = rd_data_reg[CODE_W-1:0];
    assign rd_param = rd_data_reg[CODE_W+PARAM_W-1:CODE_W];

endmodule

// ===== hdl/gcf_ctrl.sv =====
// Queue pointers, counters and the input stage register.
module gcf_ctrl #(
    parameter int QUEUE_DEPTH = 256,
    localparam int PTR_W = $clog2(QUEUE_DEPTH),
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  gcf_pkg::mode_t              mode,
    input  logic [gcf_pkg::CODE_W-1:0]  code,
    input  logic [gcf_pkg::CODE_W-1:0]  rd_code,
    input  logic                        out_ready,
    output logic                        wr_en,
    output logic [PTR_W-1:0]            wr_addr,
    output logic                        rd_en,
    output logic [PTR_W-1:0]            rd_addr,
    output logic                        st_valid,
    output gcf_pkg::stage_flags_t       st_flags,
    output logic [LVL_W-1:0]            st_level,
    output logic [LVL_W-1:0]            st_stack
);
    import gcf_pkg::*;

    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [LVL_W-1:0] count_reg, count_next;
    logic [LVL_W-1:0] stack_reg, stack_next;
    logic             pend_reg, pend_next;
    logic             st_valid_reg, st_valid_next;
    stage_flags_t     st_flags_reg, flags_next;
    logic [LVL_W-1:0] st_level_reg;
    logic [LVL_W-1:0] st_stack_reg;

    logic             accept;
    logic             full;
    logic             empty;
    logic             dec;
    logic [LVL_W-1:0] stack_eff;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    assign s_ready = !st_valid_reg || out_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == LVL_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);

    // apply the stack decrement of the pop taken last cycle, now that its code is read
    assign dec       = pend_reg && is_stack_cmd(rd_code) && (stack_reg != '0);
    assign stack_eff = stack_reg - LVL_W'(dec);

    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        stack_next  = stack_eff;
        flags_next  = '0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        if (accept) begin
            case (mode)
                MODE_PUSH: begin
                    if (full) begin
                        flags_next.overflow = 1'b1;
                    end else begin
                        wr_en       = 1'b1;
                        wr_ptr_next = advance(wr_ptr_reg);
                        count_next  = count_reg + 1'b1;
                        if (is_stack_cmd(code)) begin
                            stack_next = stack_eff + 1'b1;
                        end
                    end
                end
                MODE_POP: begin
                    if (!empty) begin
                        rd_en                = 1'b1;
                        flags_next.pop_valid = 1'b1;
                        rd_ptr_next          = advance(rd_ptr_reg);
                        count_next           = count_reg - 1'b1;
                    end
                end
                MODE_CLEAR: begin
                    rd_ptr_next = '0;
                    wr_ptr_next = '0;
                    count_next  = '0;
                    stack_next  = '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign pend_next     = rd_en;
    assign st_valid_next = accept ? 1'b1 : (out_ready ? 1'b0 : st_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            count_reg    <= '0;
            stack_reg    <= '0;
            pend_reg     <= 1'b0;
            st_valid_reg <= 1'b0;
        end else begin
            rd_ptr_reg   <= rd_ptr_next;
            wr_ptr_reg   <= wr_ptr_next;
            count_reg    <= count_next;
            stack_reg    <= stack_next;
            pend_reg     <= pend_next;
            st_valid_reg <= st_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_flags_reg <= flags_next;
            st_level_reg <= count_next;
            st_stack_reg <= stack_next;
        end
    end

    assign wr_addr  = wr_ptr_reg;
    assign rd_addr  = rd_ptr_reg;
    assign st_valid = st_valid_reg;
    assign st_flags = st_flags_reg;
    assign st_level = st_level_reg;
    assign st_stack = st_stack_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= LVL_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stack_eff <= count_reg)
        else $error("stack command count above entry count");

    a_overflow_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (mode == MODE_PUSH) && full
        |=> (count_reg == $past(count_reg)) && (wr_ptr_reg == $past(wr_ptr_reg)))
        else $error("dropped push changed queue state");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        st_valid_reg && !out_ready |=> st_valid_reg && $stable(st_level_reg))
        else $error("stage lost while output stalled");

endmodule

// ===== hdl/gcf_status.sv =====
// Result register: forms the status flags and holds the result beat.
module gcf_status #(
    parameter int QUEUE_DEPTH = 256,
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         st_valid,
    input  gcf_pkg::stage_flags_t        st_flags,
    input  logic [LVL_W-1:0]             st_level,
    input  logic [LVL_W-1:0]             st_stack,
    input  logic [gcf_pkg::CODE_W-1:0]   rd_code,
    input  logic [gcf_pkg::PARAM_W-1:0]  rd_param,
    input  logic [LVL_W-1:0]             threshold,
    output logic                         out_ready,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_pop_valid,
    output logic [gcf_pkg::CODE_W-1:0]   m_code,
    output logic [gcf_pkg::PARAM_W-1:0]  m_param,
    output logic [LVL_W-1:0]             m_level,
    output logic                         m_low,
    output logic                         m_empty,
    output logic                         m_busy,
    output logic                         m_overflow
);
    import gcf_pkg::*;

    logic                m_valid_reg, m_valid_next;
    logic                pop_valid_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [PARAM_W-1:0]  param_reg;
    logic [LVL_W-1:0]    level_reg;
    logic                low_reg;
    logic                empty_reg;
    logic                busy_reg;
    logic                overflow_reg;

    logic                load;
    logic                dec;
    logic [LVL_W-1:0]    stack_after;

    assign out_ready    = !m_valid_reg || m_ready;
    assign load         = st_valid && out_ready;
    assign m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    assign dec         = st_flags.pop_valid && is_stack_cmd(rd_code) && (st_stack != '0);
    assign stack_after = st_stack - LVL_W'(dec);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pop_valid_reg <= st_flags.pop_valid;
            code_reg      <= st_flags.pop_valid ? rd_code : '0;
            param_reg     <= st_flags.pop_valid ? rd_param : '0;
            level_reg     <= st_level;
            low_reg       <= (st_level <= threshold);
            empty_reg     <= (st_level == '0);
            busy_reg      <= (stack_after != '0);
            overflow_reg  <= st_flags.overflow;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_pop_valid = pop_valid_reg;
    assign m_code      = code_reg;
    assign m_param     = param_reg;
    assign m_level     = level_reg;
    assign m_low       = low_reg;
    assign m_empty     = empty_reg;
    assign m_busy      = busy_reg;
    assign m_overflow  = overflow_reg;

endmodule

// ===== hdl/graphics_command_fifo_top.sv =====
// Top level of the graphics command queue.
//
// Input beats on s_axis carry one queue operation: tuser selects push, pop
// or clear, and tdata carries the command byte and parameter word for a push.
// Every input beat yields exactly one result beat on m_axis: the popped entry
// (tuser high when a pop returned one) and the fill level, low/DMA-request,
// empty, stack-busy and overflow flags after the operation.
// A push into a full queue is dropped and flagged; a pop from an empty queue
// returns zeros with tuser low.
// Throughput is one beat per cycle while m_axis does not stall, set by the
// pointer and counter update and the one-write one-read entry memory. Each
// input beat passes the memory read stage and then the result register.
// When m_axis stalls, the result register and the stage ahead of it hold
// their beats and s_axis_tready drops once both are full.
// Reset clears pointers, counters and pipeline valids and sets the low
// threshold to 127; entry contents stay unknown and need no clearing pass.
// The low threshold lies at APB byte address 0.
module graphics_command_fifo_top #(
    parameter int QUEUE_DEPTH = 256,
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1),
    localparam int OUT_W = ((gcf_pkg::CODE_W + gcf_pkg::PARAM_W + LVL_W + 4 + 7) / 8) * 8
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command_code [7:0], command_parameter [39:8]
    input  logic [39:0] s_axis_tdata,
    // mode [1:0]
    input  logic [1:0]  s_axis_tuser,

    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // popped_command, popped_parameter, fill_level, level_low, queue_empty,
    // stack_busy, overflow
    output logic [OUT_W-1:0] m_axis_tdata,
    // pop_valid
    output logic             m_axis_tuser,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gcf_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int THRESHOLD_INIT =
        (THRESHOLD_RESET > QUEUE_DEPTH) ? QUEUE_DEPTH : THRESHOLD_RESET;
    localparam logic REG_LOW_THRESHOLD = 1'b0;

    logic [LVL_W-1:0]   threshold_reg, threshold_next;
    logic               cfg_write;
    logic               cfg_hit;

    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    logic               rd_en;
    logic [PTR_W-1:0]   rd_addr;
    logic [CODE_W-1:0]  rd_code;
    logic [PARAM_W-1:0] rd_param;
    logic               out_ready;
    logic               st_valid;
    stage_flags_t       st_flags;
    logic [LVL_W-1:0]   st_level;
    logic [LVL_W-1:0]   st_stack;

    logic               m_pop_valid;
    logic [CODE_W-1:0]  m_code;
    logic [PARAM_W-1:0] m_param;
    logic [LVL_W-1:0]   m_level;
    logic               m_low;
    logic               m_empty;
    logic               m_busy;
    logic               m_overflow;

    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[2] == REG_LOW_THRESHOLD);
    assign cfg_write = psel && penable && pwrite && pready && cfg_hit;

    assign threshold_next = cfg_write ? pwdata[LVL_W-1:0] : threshold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= LVL_W'(THRESHOLD_INIT);
        end else begin
            threshold_reg <= threshold_next;
        end
    end

    assign prdata = cfg_hit ? 32'(threshold_reg) : '0;

    gcf_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .mode      (mode_t'(s_axis_tuser)),
        .code      (s_axis_tdata[CODE_W-1:0]),
        .rd_code   (rd_code),
        .out_ready (out_ready),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .st_valid  (st_valid),
        .st_flags  (st_flags),
        .st_level  (st_level),
        .st_stack  (st_stack)
    );

    gcf_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_store (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_code  (s_axis_tdata[CODE_W-1:0]),
        .wr_param (s_axis_tdata[CODE_W+PARAM_W-1:CODE_W]),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_code  (rd_code),
        .rd_param (rd_param)
    );

    gcf_status #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_status (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .st_valid    (st_valid),
        .st_flags    (st_flags),
        .st_level    (st_level),
        .st_stack    (st_stack),
        .rd_code     (rd_code),
        .rd_param    (rd_param),
        .threshold   (threshold_reg),
        .out_ready   (out_ready),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_pop_valid (m_pop_valid),
        .m_code      (m_code),
        .m_param     (m_param),
        .m_level     (m_level),
        .m_low       (m_low),
        .m_empty     (m_empty),
        .m_busy      (m_busy),
        .m_overflow  (m_overflow)
    );

    assign m_axis_tdata = OUT_W'({m_overflow, m_busy, m_empty, m_low, m_level, m_param, m_code});
    assign m_axis_tuser = m_pop_valid;

endmodule
